FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define EGS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Temporal property checked at every clock edge outside reset.
`define EGS_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: rtl/egs_pkg.sv
// ----------------------------------------------------------------------------
// egs_pkg
// Shared types and constants of the epidemic grid stencil step unit.
// ----------------------------------------------------------------------------
package egs_pkg;

  localparam int GRID_W  = 11;
  localparam int DUR_W   = 6;
  localparam int THR_W   = 4;
  localparam int COUNT_W = 21;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [GRID_W-1:0] GRID_RESET   = 11'd160;
  localparam logic [DUR_W-1:0]  INFECT_RESET = 6'd10;
  localparam logic [DUR_W-1:0]  IMMUNE_RESET = 6'd30;

  // Register indexes, byte address is four times the index.
  localparam logic [1:0] REG_GRID_SIZE = 2'd0;
  localparam logic [1:0] REG_INFECT    = 2'd1;
  localparam logic [1:0] REG_IMMUNE    = 2'd2;

  // Per-item control produced by the front end.
  typedef struct packed {
    logic col_first;
    logic emit_main;
    logic emit_edge;
    logic frame_end;
    logic above_ok;
    logic middle_ok;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

  typedef struct packed {
    logic [DUR_W-1:0] infect;
    logic [DUR_W-1:0] immune;
  } dur_cfg_t;

endpackage

FILE: rtl/egs_cell_in_if.sv
// ----------------------------------------------------------------------------
// egs_cell_in_if
// Input cell channel: valid/ready handshake with cell payload.
// ----------------------------------------------------------------------------
interface egs_cell_in_if #(parameter int STATE_BITS = 7);
  import egs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [STATE_BITS-1:0] cell_state;
  logic [THR_W-1:0]             contact_threshold;

  modport source (output valid, cmd, cell_state, contact_threshold, input ready);
  modport sink (input valid, cmd, cell_state, contact_threshold, output ready);
endinterface

FILE: rtl/egs_cell_out_if.sv
// ----------------------------------------------------------------------------
// egs_cell_out_if
// Result channel: valid/ready handshake with next-generation cell payload.
// ----------------------------------------------------------------------------
interface egs_cell_out_if #(parameter int STATE_BITS = 7);
  import egs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [STATE_BITS-1:0] new_state;
  logic                         newly_infected;
  logic [COUNT_W-1:0]           infection_count;
  logic                         last_of_frame;

  modport source (output valid, new_state, newly_infected, infection_count, last_of_frame,
                  input ready);
  modport sink (input valid, new_state, newly_infected, infection_count, last_of_frame,
                output ready);
endinterface

FILE: rtl/egs_cfg.sv
// ----------------------------------------------------------------------------
// egs_cfg
// APB-style register block: grid size and the two durations.
// ----------------------------------------------------------------------------
module egs_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [egs_pkg::ADDR_W-1:0] paddr,
  input  logic [egs_pkg::DATA_W-1:0] pwdata,
  output logic [egs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [egs_pkg::GRID_W-1:0] grid_size,
  output egs_pkg::dur_cfg_t          durations,
  output logic                       restart
);
  import egs_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // The raster position restarts at the same edge that takes the new size.
  assign restart = wr_en && (reg_idx == REG_GRID_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size        <= GRID_RESET;
      durations.infect <= INFECT_RESET;
      durations.immune <= IMMUNE_RESET;
    end else begin
      if (wr_en) begin
        case (reg_idx)
          REG_GRID_SIZE: grid_size <= pwdata[GRID_W-1:0];
          REG_INFECT: durations.infect <= pwdata[DUR_W-1:0];
          REG_IMMUNE: durations.immune <= pwdata[DUR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_SIZE: prdata = DATA_W'(grid_size);
      REG_INFECT:    prdata = DATA_W'(durations.infect);
      REG_IMMUNE:    prdata = DATA_W'(durations.immune);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/egs_front.sv
// ----------------------------------------------------------------------------
// egs_front
// Accepts cells, tracks raster position and tags each item with its work.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egs_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int STATE_BITS = 7,
  parameter int ITEM_W     = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [egs_pkg::GRID_W-1:0] grid_size,
  input  logic                       restart,
  egs_cell_in_if.sink                cell_in,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [ITEM_W-1:0]          push_data
);
  import egs_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int NW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0]                col;
  logic [NW-1:0]                row;
  logic [NW-1:0]                n_eff;
  logic                         acc;
  logic                         flush;
  logic                         last_col;
  logic signed [STATE_BITS-1:0] cur;
  logic [THR_W-1:0]             thr;
  flags_t                       fl;

  always_comb begin
    if (grid_size < GRID_W'(2)) begin
      n_eff = NW'(2);
    end else if (32'(grid_size) > MAX_WIDTH) begin
      n_eff = NW'(MAX_WIDTH);
    end else begin
      n_eff = NW'(grid_size);
    end
  end

  assign cell_in.ready = push_ready;
  assign push_valid    = cell_in.valid;
  assign acc           = cell_in.valid && push_ready;

  // The row just past the bottom edge carries zero cells only.
  assign flush    = row >= n_eff;
  assign last_col = (NW'(col) + NW'(1)) == n_eff;
  assign cur      = (flush || cell_in.cmd) ? '0 : cell_in.cell_state;
  assign thr      = flush ? '0 : cell_in.contact_threshold;

  always_comb begin
    fl.col_first = col == '0;
    fl.emit_main = (row != '0) && (col != '0);
    fl.emit_edge = (row != '0) && last_col;
    fl.frame_end = flush && last_col;
    fl.above_ok  = row > NW'(1);
    fl.middle_ok = row != '0;
  end

  assign push_data = {fl, col, cur, thr};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      if (last_col) begin
        col <= '0;
        row <= flush ? '0 : row + NW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  `EGS_ASSERT_PROP(a_frame_wrap, (restart || (acc && fl.frame_end)) |=> (row == '0 && col == '0), "raster position not cleared at frame end")
  `EGS_ASSERT_ALWAYS(a_col_in_grid, NW'(col) < n_eff || restart || $past(restart), "column beyond grid")

endmodule

FILE: rtl/egs_queue.sv
// ----------------------------------------------------------------------------
// egs_queue
// Small register FIFO that decouples the front end from the stencil back end.
// ----------------------------------------------------------------------------
module egs_queue #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     count;
  logic              push;
  logic              pop;

  assign push_ready = count != NW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

endmodule

FILE: rtl/egs_back.sv
// ----------------------------------------------------------------------------
// egs_back
// Line buffers, 3x3 window, update rules, infection count and result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egs_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int STATE_BITS = 7,
  parameter int ITEM_W     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  egs_pkg::dur_cfg_t  durations,
  input  logic               restart,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ITEM_W-1:0]  pop_data,
  egs_cell_out_if.source     cell_out
);
  import egs_pkg::*;

  localparam int SB     = STATE_BITS;
  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ODEPTH = 4;
  localparam int OPW    = $clog2(ODEPTH);
  localparam int OCW    = $clog2(ODEPTH + 1);

  // Line buffers: contents are only used after the current frame wrote them.
  logic signed [SB-1:0] above_mem  [MAX_WIDTH];
  logic signed [SB-1:0] middle_mem [MAX_WIDTH];
  logic [THR_W-1:0]     thr_mem    [MAX_WIDTH];

  flags_t               q_flags;
  logic [CW-1:0]        q_col;
  logic signed [SB-1:0] q_cur;
  logic [THR_W-1:0]     q_thr;

  logic                 b_valid;
  flags_t               b_flags;
  logic [CW-1:0]        b_col;
  logic signed [SB-1:0] b_cur;
  logic [THR_W-1:0]     b_thr;
  logic signed [SB-1:0] up_q;
  logic signed [SB-1:0] mid_q;
  logic [THR_W-1:0]     tmid_q;
  logic [THR_W-1:0]     thr_left;

  logic signed [SB-1:0] win      [3][3];
  logic signed [SB-1:0] win_next [3][3];
  logic signed [SB-1:0] up_g;
  logic signed [SB-1:0] mid_g;

  logic                 b_done;
  logic                 pop;
  logic [3:0]           cnt_main;
  logic [3:0]           cnt_edge;
  logic                 ni_main;
  logic                 ni_edge;
  logic signed [SB-1:0] nv_main;
  logic signed [SB-1:0] nv_edge;
  logic [COUNT_W-1:0]   inf_count;
  logic [COUNT_W-1:0]   count_a;
  logic [COUNT_W-1:0]   count_b;

  logic signed [SB-1:0] o_state [ODEPTH];
  logic                 o_ni    [ODEPTH];
  logic [COUNT_W-1:0]   o_count [ODEPTH];
  logic                 o_last  [ODEPTH];
  logic [OPW-1:0]       o_wr;
  logic [OPW-1:0]       o_rd;
  logic [OCW-1:0]       o_cnt;
  logic                 o_pop;
  logic [OCW-1:0]       n_push;

  function automatic logic is_pos(input logic signed [SB-1:0] v);
    return !v[SB-1] && (v != '0);
  endfunction

  function automatic logic [3:0] ones8(input logic [7:0] b);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + {3'b000, b[i]};
    end
    return s;
  endfunction

  // Returns {newly infected, next state} for one cell.
  function automatic logic [SB:0] next_cell(input logic signed [SB-1:0] center,
                                            input logic [3:0] pos,
                                            input logic [THR_W-1:0] thr,
                                            input dur_cfg_t dur);
    logic signed [SB-1:0] nv;
    logic                 ni;
    ni = 1'b0;
    if (is_pos(center)) begin
      nv = (center == SB'(1)) ? ('0 - SB'(dur.immune)) : center - SB'(1);
    end else if (center[SB-1]) begin
      nv = center + SB'(1);
    end else if (pos > thr) begin
      nv = SB'(dur.infect);
      ni = 1'b1;
    end else begin
      nv = '0;
    end
    return {ni, nv};
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c,
                                                 input logic inc);
    return (inc && c != COUNT_MAX) ? c + COUNT_W'(1) : c;
  endfunction

  assign {q_flags, q_col, q_cur, q_thr} = pop_data;

  // A stage-B item retires only when the result queue has room for two.
  assign b_done    = b_valid && (o_cnt <= OCW'(ODEPTH - 2));
  assign pop_ready = !b_valid || b_done;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      up_q    <= above_mem[q_col];
      mid_q   <= middle_mem[q_col];
      tmid_q  <= thr_mem[q_col];
      b_flags <= q_flags;
      b_col   <= q_col;
      b_cur   <= q_cur;
      b_thr   <= q_thr;
    end
  end

  always_ff @(posedge clk) begin
    if (b_done) begin
      above_mem[b_col]  <= mid_g;
      middle_mem[b_col] <= b_cur;
      thr_mem[b_col]    <= b_thr;
    end
  end

  assign up_g  = b_flags.above_ok ? up_q : '0;
  assign mid_g = b_flags.middle_ok ? mid_q : '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_flags.col_first) begin
        win_next[i][0] = '0;
        win_next[i][1] = '0;
      end else begin
        win_next[i][0] = win[i][1];
        win_next[i][1] = win[i][2];
      end
    end
    win_next[0][2] = up_g;
    win_next[1][2] = mid_g;
    win_next[2][2] = b_cur;
  end

  assign cnt_main = ones8({is_pos(win_next[0][0]), is_pos(win_next[0][1]),
                           is_pos(win_next[0][2]), is_pos(win_next[1][0]),
                           is_pos(win_next[1][2]), is_pos(win_next[2][0]),
                           is_pos(win_next[2][1]), is_pos(win_next[2][2])});
  // The right edge cell has no column beyond it.
  assign cnt_edge = ones8({3'b000, is_pos(win_next[0][1]), is_pos(win_next[0][2]),
                           is_pos(win_next[1][1]), is_pos(win_next[2][1]),
                           is_pos(win_next[2][2])});

  assign {ni_main, nv_main} = next_cell(win_next[1][1], cnt_main, thr_left, durations);
  assign {ni_edge, nv_edge} = next_cell(win_next[1][2], cnt_edge, tmid_q, durations);

  assign count_a = sat_inc(inf_count, b_flags.emit_main && ni_main);
  assign count_b = sat_inc(count_a, b_flags.emit_edge && ni_edge);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
      inf_count <= '0;
    end else if (b_done) begin
      win       <= win_next;
      inf_count <= b_flags.frame_end ? '0 : count_b;
    end
  end

  always_ff @(posedge clk) begin
    if (b_done) begin
      thr_left <= tmid_q;
    end
  end

  // Result queue.
  assign n_push = b_done ? (OCW'(b_flags.emit_main) + OCW'(b_flags.emit_edge)) : '0;
  assign o_pop  = cell_out.valid && cell_out.ready;

  always_ff @(posedge clk) begin
    if (b_done && b_flags.emit_main) begin
      o_state[o_wr] <= nv_main;
      o_ni[o_wr]    <= ni_main;
      o_count[o_wr] <= count_a;
      o_last[o_wr]  <= 1'b0;
    end
    if (b_done && b_flags.emit_edge) begin
      o_state[o_wr + OPW'(b_flags.emit_main)] <= nv_edge;
      o_ni[o_wr + OPW'(b_flags.emit_main)]    <= ni_edge;
      o_count[o_wr + OPW'(b_flags.emit_main)] <= count_b;
      o_last[o_wr + OPW'(b_flags.emit_main)]  <= b_flags.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr  <= '0;
      o_rd  <= '0;
      o_cnt <= '0;
    end else begin
      o_wr  <= o_wr + OPW'(n_push);
      o_rd  <= o_rd + OPW'(o_pop);
      o_cnt <= o_cnt + n_push - OCW'(o_pop);
    end
  end

  assign cell_out.valid           = o_cnt != '0;
  assign cell_out.new_state       = o_state[o_rd];
  assign cell_out.newly_infected  = o_ni[o_rd];
  assign cell_out.infection_count = o_count[o_rd];
  assign cell_out.last_of_frame   = o_last[o_rd];

  `EGS_ASSERT_ALWAYS(a_oq_bound, o_cnt <= OCW'(ODEPTH), "result queue overfilled")
  `EGS_ASSERT_PROP(a_count_clear, (b_done && b_flags.frame_end) |=> (inf_count == '0), "infection count kept past frame end")

endmodule

FILE: rtl/epidemic_grid_stencil_step_unit.sv
// A cell's result comes from the input one row and one column later, which passes
// through the input queue, stage B and the result queue. Throughput: one cell per
// cycle unless a channel stalls; a row's last item gives two results on the single port.
// Line buffers: at most one read and one write per cycle, at the new and stage-B columns.
// Reset (rst, synchronous) clears position, window, counts and queues; buffers need none.
// ----------------------------------------------------------------------------
// epidemic_grid_stencil_step_unit
// One generation of a square-grid SIRS automaton over a raster cell stream.
// ----------------------------------------------------------------------------
module epidemic_grid_stencil_step_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int STATE_BITS = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [egs_pkg::ADDR_W-1:0] paddr,
  input  logic [egs_pkg::DATA_W-1:0] pwdata,
  output logic [egs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  egs_cell_in_if.sink                cell_in,
  egs_cell_out_if.source             cell_out
);
  import egs_pkg::*;

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ITEM_W = FLAGS_W + CW + STATE_BITS + THR_W;

  logic [GRID_W-1:0] grid_size;
  dur_cfg_t          durations;
  logic              restart;
  logic              f_valid;
  logic              f_ready;
  logic [ITEM_W-1:0] f_data;
  logic              q_valid;
  logic              q_ready;
  logic [ITEM_W-1:0] q_data;

  egs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .grid_size (grid_size),
    .durations (durations),
    .restart   (restart)
  );

  egs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .STATE_BITS (STATE_BITS),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .grid_size  (grid_size),
    .restart    (restart),
    .cell_in    (cell_in),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  egs_queue #(
    .DATA_W (ITEM_W),
    .DEPTH  (4)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  egs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .STATE_BITS (STATE_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .durations (durations),
    .restart   (restart),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data),
    .cell_out  (cell_out)
  );

endmodule

FILE: bench/tb_epidemic_grid_stencil_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epidemic_grid_stencil_step_unit
// Streams raster grids through the stencil unit and checks every cell result.
// A cycle-free predictor of one SIRS generation runs beside the block and
// queues the expected results of each accepted cell; the results coming out
// are compared in order. Registers are reprogrammed between frames, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_epidemic_grid_stencil_step_unit;
  import egs_pkg::*;

  localparam int MAX_W = 1024;
  localparam int STATE_W = 7;
  localparam int QUIET_LIMIT = 2000;

  localparam logic CMD_CELL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [STATE_W-1:0] cell_state;
    logic [THR_W-1:0]          contact_threshold;
  } cell_item_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] new_state;
    logic                      newly_infected;
    logic [COUNT_W-1:0]        infection_count;
    logic                      last_of_frame;
  } cell_result_t;

  // Predicts one generation of the automaton and holds the cell results still
  // to come out of the block.
  class generation_tracker;
    logic [GRID_W-1:0]  side_reg;
    logic [DUR_W-1:0]   infect_len;
    logic [DUR_W-1:0]   immune_len;
    int                 above_row[MAX_W];
    int                 middle_row[MAX_W];
    logic [THR_W-1:0]   thr_row[MAX_W];
    int                 win[3][3];
    logic [THR_W-1:0]   thr_left;
    int unsigned        col;
    int unsigned        row;
    logic [COUNT_W-1:0] infections;
    cell_result_t       next_cells[$];
    int                 mismatches;

    function new();
      side_reg = GRID_RESET;
      infect_len = INFECT_RESET;
      immune_len = IMMUNE_RESET;
      mismatches = 0;
      foreach (above_row[i]) begin
        above_row[i] = 0;
        middle_row[i] = 0;
        thr_row[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      foreach (win[i, j]) win[i][j] = 0;
      thr_left = '0;
      col = 0;
      row = 0;
      infections = '0;
    endfunction

    function int unsigned side();
      if (side_reg < 2) return 2;
      if (side_reg > MAX_W) return MAX_W;
      return side_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_GRID_SIZE: begin
          side_reg = value[GRID_W-1:0];
          restart();
        end
        REG_INFECT: infect_len = value[DUR_W-1:0];
        REG_IMMUNE: immune_len = value[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    function int infected(int v);
      return (v > 0) ? 1 : 0;
    endfunction

    function cell_result_t judge(int centre, int hits, logic [THR_W-1:0] thr, bit last);
      cell_result_t res;
      int nv;
      res.newly_infected = 1'b0;
      if (centre > 0) begin
        nv = (centre == 1) ? -int'(immune_len) : centre - 1;
      end else if (centre < 0) begin
        nv = centre + 1;
      end else if (hits > int'(thr)) begin
        nv = int'(infect_len);
        res.newly_infected = 1'b1;
        if (infections != COUNT_MAX) infections++;
      end else begin
        nv = 0;
      end
      res.new_state = STATE_W'(nv);
      res.infection_count = infections;
      res.last_of_frame = last;
      return res;
    endfunction

    function void take_cell(cell_item_t it);
      int unsigned n;
      int unsigned c;
      int unsigned r;
      int cur;
      int up;
      int mid;
      int hits;
      int i;
      logic [THR_W-1:0] thr;
      logic [THR_W-1:0] tmid;
      bit flush;
      n = side();
      c = col;
      r = row;
      flush = (r >= n);
      cur = (flush || it.cmd == CMD_FLUSH) ? 0 : int'(it.cell_state);
      thr = flush ? '0 : it.contact_threshold;
      if (c >= n) c = 0;
      if (c == 0) begin
        foreach (win[a, b]) win[a][b] = 0;
        thr_left = '0;
      end
      up = (r >= 2) ? above_row[c] : 0;
      mid = (r >= 1) ? middle_row[c] : 0;
      tmid = thr_row[c];
      for (i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = cur;
      above_row[c] = mid;
      middle_row[c] = cur;
      thr_row[c] = thr;

      // The window center is the cell one row up and one column left.
      if (r >= 1 && c >= 1) begin
        hits = infected(win[0][0]) + infected(win[0][1]) + infected(win[0][2])
             + infected(win[1][0]) + infected(win[1][2])
             + infected(win[2][0]) + infected(win[2][1]) + infected(win[2][2]);
        next_cells.push_back(judge(win[1][1], hits, thr_left, 1'b0));
      end
      // At the last column the right-edge cell is emitted too, with zero beyond it.
      if (r >= 1 && c == n - 1) begin
        hits = infected(win[0][1]) + infected(win[0][2]) + infected(win[1][1])
             + infected(win[2][1]) + infected(win[2][2]);
        next_cells.push_back(judge(win[1][2], hits, tmid, r >= n));
      end
      thr_left = tmid;

      c++;
      if (c >= n) begin
        c = 0;
        r++;
        if (r > n) begin
          restart();
          return;
        end
      end
      col = c;
      row = r;
    endfunction

    function void compare_cell(cell_result_t got);
      cell_result_t want;
      if (next_cells.size() == 0) begin
        $error("result with none pending: new_state %0d, count %0d",
               got.new_state, got.infection_count);
        mismatches++;
        return;
      end
      want = next_cells.pop_front();
      if (got.new_state !== want.new_state) begin
        $error("new_state: expected %0d, got %0d", want.new_state, got.new_state);
        mismatches++;
      end
      if (got.newly_infected !== want.newly_infected) begin
        $error("newly_infected: expected %0d, got %0d",
               want.newly_infected, got.newly_infected);
        mismatches++;
      end
      if (got.infection_count !== want.infection_count) begin
        $error("infection_count: expected %0d, got %0d",
               want.infection_count, got.infection_count);
        mismatches++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $error("last_of_frame: expected %0d, got %0d",
               want.last_of_frame, got.last_of_frame);
        mismatches++;
      end
    endfunction

    function void close_out();
      if (next_cells.size() != 0) begin
        $error("%0d expected results never arrived", next_cells.size());
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  egs_cell_in_if #(.STATE_BITS(STATE_W)) cells_in();
  egs_cell_out_if #(.STATE_BITS(STATE_W)) cells_out();

  epidemic_grid_stencil_step_unit #(
    .MAX_WIDTH(MAX_W),
    .STATE_BITS(STATE_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cell_in(cells_in),
    .cell_out(cells_out)
  );

  generation_tracker tracker = new();
  int src_gap = 0;
  int sink_stall = 0;
  int quiet_cycles = 0;
  cell_result_t seen;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    cells_out.ready = ($urandom_range(99) >= sink_stall);
  end

  // Result checking and the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst && cells_out.valid && cells_out.ready) begin
      seen.new_state = cells_out.new_state;
      seen.newly_infected = cells_out.newly_infected;
      seen.infection_count = cells_out.infection_count;
      seen.last_of_frame = cells_out.last_of_frame;
      tracker.compare_cell(seen);
    end
    if ((cells_in.valid && cells_in.ready) || (cells_out.valid && cells_out.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic cell_item_t mk(logic cmd, int state, int thr);
    cell_item_t it;
    it.cmd = cmd;
    it.cell_state = STATE_W'(state);
    it.contact_threshold = THR_W'(thr);
    return it;
  endfunction

  function automatic cell_item_t random_cell();
    int pick;
    int mag;
    pick = $urandom_range(99);
    mag = ($urandom_range(1) == 0) ? $urandom_range(3, 1) : $urandom_range(63, 1);
    if (pick < 40) mag = 0;
    else if (pick < 70) mag = mag;
    else if (pick < 99) mag = -mag;
    else mag = -64;
    return mk(($urandom_range(99) < 3) ? CMD_FLUSH : CMD_CELL, mag,
              ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(15));
  endfunction

  function automatic logic [DATA_W-1:0] pick_duration();
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return 63;
      default: return $urandom_range(63, 1);
    endcase
  endfunction

  task automatic send_cell(cell_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_gap) begin
      cells_in.valid = 1'b0;
      @(negedge clk);
    end
    cells_in.valid = 1'b1;
    cells_in.cmd = it.cmd;
    cells_in.cell_state = it.cell_state;
    cells_in.contact_threshold = it.contact_threshold;
    do @(posedge clk); while (!cells_in.ready);
    tracker.take_cell(it);
  endtask

  // Holds the input until every expected result has been taken.
  task automatic drain();
    @(negedge clk);
    cells_in.valid = 1'b0;
    while (tracker.next_cells.size() != 0) @(posedge clk);
  endtask

  // Corner and first-column items leave no result, so give the pipeline time to empty.
  task automatic settle();
    drain();
    repeat (10) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Sends items first..first+count-1 of a frame; rows past the grid are flush rows.
  task automatic send_frame(int first, int count, int pause_at);
    int n;
    int k;
    cell_item_t it;
    n = tracker.side();
    for (k = first; k < first + count; k++) begin
      if (k == pause_at) drain();
      it = random_cell();
      if (k / n >= n) begin
        if ($urandom_range(99) < 90) it = mk(CMD_FLUSH, 0, 0);
        else it.cmd = CMD_CELL;
      end
      send_cell(it);
    end
  endtask

  task automatic random_frames(int budget);
    int sent;
    int n;
    int total;
    int cut;
    int pick;
    sent = 0;
    while (sent < budget) begin
      settle();
      if ($urandom_range(99) < 40) apb_write(REG_INFECT, pick_duration());
      if ($urandom_range(99) < 40) apb_write(REG_IMMUNE, pick_duration());
      pick = $urandom_range(99);
      if (pick < 8) apb_write(REG_GRID_SIZE, $urandom_range(1));
      else if (pick < 80) apb_write(REG_GRID_SIZE, $urandom_range(6, 2));
      else apb_write(REG_GRID_SIZE, $urandom_range(12, 7));
      n = tracker.side();
      total = n * n + n;
      // A cut-short frame is restarted by the next size write.
      if ($urandom_range(99) < 15) total = $urandom_range(total - 1, 1);
      if ($urandom_range(99) < 15 && total > 2) begin
        cut = $urandom_range(total - 1, 1);
        send_frame(0, cut, -1);
        settle();
        apb_write(REG_INFECT, pick_duration());
        send_frame(cut, total - cut, -1);
      end else begin
        send_frame(0, total, ($urandom_range(99) < 10) ? $urandom_range(total - 1) : -1);
      end
      sent += total;
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cells_in.valid = 1'b0;
    cells_in.cmd = CMD_CELL;
    cells_in.cell_state = '0;
    cells_in.contact_threshold = '0;
    cells_out.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    src_gap = 18;
    sink_stall = 63;
    // Reset grid size and durations: one row and a bit, with a full stop in the second row.
    send_frame(0, 160 + 4, 162);
    settle();

    // Three by three: extremes, countdown into immunity, early flush inside the grid,
    // a count equal to the threshold, and a flush row fed with plain cells.
    apb_write(REG_GRID_SIZE, 3);
    send_cell(mk(CMD_CELL, 5, 0));
    send_cell(mk(CMD_CELL, 0, 0));
    send_cell(mk(CMD_CELL, 63, 15));
    send_cell(mk(CMD_CELL, 1, 3));
    send_cell(mk(CMD_FLUSH, -5, 0));
    send_cell(mk(CMD_CELL, -63, 0));
    send_cell(mk(CMD_CELL, -1, 0));
    send_cell(mk(CMD_CELL, 0, 15));
    send_cell(mk(CMD_CELL, 0, 0));
    send_cell(mk(CMD_FLUSH, 0, 0));
    send_cell(mk(CMD_CELL, 40, 9));
    send_cell(mk(CMD_FLUSH, -7, 15));
    settle();

    // Zero durations: an ending infection drops to zero, a new one starts at zero.
    apb_write(REG_INFECT, 0);
    apb_write(REG_IMMUNE, 0);
    apb_write(REG_GRID_SIZE, 2);
    send_cell(mk(CMD_CELL, 1, 0));
    send_cell(mk(CMD_CELL, 0, 0));
    send_cell(mk(CMD_CELL, 0, 15));
    send_cell(mk(CMD_CELL, -1, 0));
    send_cell(mk(CMD_FLUSH, 0, 0));
    send_cell(mk(CMD_FLUSH, 0, 0));
    settle();

    apb_write(REG_GRID_SIZE, 0);
    send_frame(0, 6, -1);
    random_frames(120);

    settle();
    src_gap = 63;
    sink_stall = 18;
    apb_write(REG_INFECT, 63);
    apb_write(REG_IMMUNE, 63);
    // An oversized grid saturates to the widest line; the short frame is cut off.
    apb_write(REG_GRID_SIZE, 2047);
    send_frame(0, 6, -1);
    settle();
    apb_write(REG_GRID_SIZE, 1);
    send_frame(0, 6, -1);
    random_frames(120);

    settle();
    src_gap = 0;
    sink_stall = 0;
    random_frames(120);

    drain();
    repeat (20) @(posedge clk);
    tracker.close_out();
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/egs_pkg.sv
rtl/egs_cell_in_if.sv
rtl/egs_cell_out_if.sv
rtl/egs_cfg.sv
rtl/egs_front.sv
rtl/egs_queue.sv
rtl/egs_back.sv
rtl/epidemic_grid_stencil_step_unit.sv
bench/tb_epidemic_grid_stencil_step_unit.sv
